### rtl/core/pdu_pkg.sv
// Shared types and constants for the parity-checked date unpacker.
package pdu_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned DateBits   = 15;
  localparam int unsigned DayBits    = 5;
  localparam int unsigned MonthBits  = 4;
  localparam int unsigned YearBits   = 11;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned CarryBits  = DateBits - 1;
  localparam int unsigned CcBits     = 4;
  localparam int unsigned Slots      = 3;
  localparam int unsigned PosBits    = 6;
  localparam int unsigned ThirdMaxPos = WordBits - 2 * DateBits;
  localparam logic [YearBits-1:0] YearBase = 11'd1970;

  localparam int unsigned AddrBits = 3;
  localparam logic RegIdxDateCount = 1'b0;

  typedef logic [DateBits-1:0] date_t;

  // One queue entry: the dates a word completes and which of them are emitted.
  typedef struct packed {
    date_t [Slots-1:0] dates;
    logic  [Slots-1:0] mask;
  } qentry_t;

  // Register write toward the front end.
  typedef struct packed {
    logic                 wr;
    logic [CountBits-1:0] count;
  } cfg_t;

endpackage

### rtl/core/pdu_if.sv
// Valid/ready channel interfaces for input words and result dates.
interface pdu_word_if import pdu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WordBits-1:0] data_word;
  logic                parity_bit;

  modport source (output valid, output data_word, output parity_bit, input ready);
  modport sink (input valid, input data_word, input parity_bit, output ready);
endinterface

interface pdu_date_if import pdu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DayBits-1:0]   day;
  logic [MonthBits-1:0] month;
  logic [YearBits-1:0]  year;
  logic                 last_of_run;

  modport source (output valid, output day, output month, output year,
                  output last_of_run, input ready);
  modport sink (input valid, input day, input month, input year,
                input last_of_run, output ready);
endinterface

### rtl/core/pdu_front.sv
// Front end: checks word parity, cuts dates from the stream and tracks the job.
module pdu_front import pdu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic [CountBits-1:0] count_i,
  input  logic                 full_i,
  pdu_word_if.sink             word_i,
  output logic                 push_o,
  output qentry_t              entry_o
);

  logic [CcBits-1:0]    cc_q, cc_d;
  logic [CarryBits-1:0] cb_q, cb_d;
  logic                 cg_q, cg_d;
  logic [CountBits-1:0] done_q, done_d;

  logic                 accept;
  logic                 good;
  logic                 has_carry;
  logic [PosBits-1:0]   need;
  logic [PosBits-1:0]   p0;
  logic [WordBits-1:0]  shifted;
  logic                 third;
  date_t                cdate;
  logic [CountBits-1:0] rem;
  logic                 active;
  logic [1:0]           ord1, ord2, n_avail, n_done;
  logic [Slots-1:0]     done_slot;
  logic [PosBits-1:0]   pos_end;
  logic                 tail;
  logic [Slots-1:0]     mask;

  assign word_i.ready = !full_i;
  assign accept = word_i.valid && word_i.ready;

  always_comb begin
    good      = ~(^word_i.data_word ^ word_i.parity_bit);
    has_carry = cc_q != '0;
    need      = PosBits'(DateBits) - PosBits'(cc_q);
    p0        = has_carry ? need : '0;
    shifted   = word_i.data_word >> p0;
    third     = p0 <= PosBits'(ThirdMaxPos);
    cdate     = DateBits'(word_i.data_word << cc_q) | DateBits'(cb_q);
    rem       = count_i - done_q;
    active    = rem != '0;
    ord1      = {1'b0, has_carry};
    ord2      = ord1 + 2'd1;
    n_avail   = ord2 + {1'b0, third};
    // A slot completes only while the job still owes dates, in stream order.
    done_slot[0] = has_carry && active;
    done_slot[1] = rem > CountBits'(ord1);
    done_slot[2] = third && (rem > CountBits'(ord2));
    n_done    = 2'(done_slot[0]) + 2'(done_slot[1]) + 2'(done_slot[2]);
    pos_end   = p0 + (third ? PosBits'(2 * DateBits) : PosBits'(DateBits));
    tail      = (rem > CountBits'(n_avail)) && (pos_end < PosBits'(WordBits));
    mask[0]   = done_slot[0] && cg_q && good;
    mask[1]   = done_slot[1] && good;
    mask[2]   = done_slot[2] && good;

    entry_o.dates = {shifted[2*DateBits-1:DateBits], shifted[DateBits-1:0], cdate};
    entry_o.mask  = mask;
    push_o        = accept && active && (mask != '0);

    cc_d   = cc_q;
    cb_d   = cb_q;
    cg_d   = cg_q;
    done_d = done_q;
    if (cfg_i.wr) begin
      cc_d   = '0;
      cb_d   = '0;
      cg_d   = 1'b1;
      done_d = '0;
    end else if (accept && active) begin
      done_d = done_q + CountBits'(n_done);
      if (tail) begin
        cc_d = CcBits'(PosBits'(WordBits) - pos_end);
        cb_d = CarryBits'(word_i.data_word >> pos_end);
        cg_d = good;
      end else begin
        cc_d = '0;
        cb_d = '0;
        cg_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      cb_q   <= '0;
      cg_q   <= 1'b1;
      done_q <= '0;
    end else begin
      cc_q   <= cc_d;
      cb_q   <= cb_d;
      cg_q   <= cg_d;
      done_q <= done_d;
    end
  end

  a_carry_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cc_q < CcBits'(DateBits))
    else $error("carry holds a whole date");

  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= count_i)
    else $error("completed dates exceed the job length");

endmodule

### rtl/core/pdu_fifo.sv
// Short queue that decouples the front end from the result sequencer.
module pdu_fifo import pdu_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qentry_t entry_i,
  input  logic    pop_i,
  output qentry_t entry_o,
  output logic    valid_o,
  output logic    full_o
);

  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  qentry_t              mem_q [Depth];
  logic [PtrBits-1:0]   wptr_q, rptr_q;
  logic [CntBits-1:0]   cnt_q;

  assign entry_o = mem_q[rptr_q];
  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntBits'(Depth);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrBits'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrBits'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

### rtl/core/pdu_back.sv
// Back end: walks each queued entry and sends its dates one per cycle while the output is ready.
module pdu_back import pdu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  qentry_t  entry_i,
  input  logic     valid_i,
  output logic     pop_o,
  pdu_date_if.source date_o
);

  logic                 cur_valid_q, cur_valid_d;
  qentry_t              cur_q, cur_d;
  logic                 out_valid_q, out_valid_d;
  logic [DayBits-1:0]   day_q, day_d;
  logic [MonthBits-1:0] month_q, month_d;
  logic [YearBits-1:0]  year_q, year_d;
  logic                 last_q, last_d;

  logic                 advance;
  logic [1:0]           sel;
  logic [Slots-1:0]     rest;
  date_t                pick;

  assign date_o.valid       = out_valid_q;
  assign date_o.day         = day_q;
  assign date_o.month       = month_q;
  assign date_o.year        = year_q;
  assign date_o.last_of_run = last_q;

  always_comb begin
    if (cur_q.mask[0]) begin
      sel = 2'd0;
    end else if (cur_q.mask[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    pick = cur_q.dates[sel];
    rest = cur_q.mask & ~(Slots'(1) << sel);

    // The output register frees up either when empty or when its date transfers.
    advance = cur_valid_q && (!out_valid_q || date_o.ready);
    pop_o   = valid_i && (!cur_valid_q || (advance && (rest == '0)));

    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    last_d      = last_q;

    if (advance) begin
      out_valid_d = 1'b1;
      day_d       = pick[DayBits-1:0];
      month_d     = pick[DayBits+MonthBits-1:DayBits];
      year_d      = YearBits'(pick[DateBits-1:DayBits+MonthBits]) + YearBase;
      last_d      = rest == '0;
      cur_d.mask  = rest;
      if (rest == '0) begin
        cur_valid_d = 1'b0;
      end
    end else if (date_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      cur_valid_d = 1'b1;
      cur_d       = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
    last_q  <= last_d;
  end

  a_cur_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (cur_q.mask != '0))
    else $error("held entry has no dates left");

endmodule

### rtl/core/parity_checked_date_unpacker.sv
// The first date of a word passes the queue, the held-entry register and the result register before it is offered.
// Throughput: one word per cycle while each word yields at most one date and the queue
// has room; a word yielding more (at most 3) holds the single result register while they drain.
// The queue between front and back lets words keep arriving while dates drain.
// Reset clears all control state and date_count; until it is written every word
// is consumed and dropped.
module parity_checked_date_unpacker import pdu_pkg::*; #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrBits-1:0]  paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  pdu_word_if.sink             word_i,
  pdu_date_if.source           date_o
);

  logic [CountBits-1:0] count_q;
  cfg_t                 cfg;
  logic                 push;
  qentry_t              push_entry;
  logic                 pop;
  qentry_t              head_entry;
  logic                 head_valid;
  logic                 full;

  assign pready    = 1'b1;
  assign cfg.wr    = psel && penable && pwrite && (paddr[2] == RegIdxDateCount);
  assign cfg.count = pwdata[CountBits-1:0];
  assign prdata    = (paddr[2] == RegIdxDateCount) ? {16'b0, count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg.wr) begin
      count_q <= cfg.count;
    end
  end

  pdu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .count_i (count_q),
    .full_i  (full),
    .word_i  (word_i),
    .push_o  (push),
    .entry_o (push_entry)
  );

  pdu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .valid_o (head_valid),
    .full_o  (full)
  );

  pdu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (head_entry),
    .valid_i (head_valid),
    .pop_o   (pop),
    .date_o  (date_o)
  );

endmodule

### dv/pdu_date_check.sv
// Predicts the dates unpacked from each accepted word and compares them with the output channel.
`timescale 1ns / 100ps

module pdu_date_check import pdu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  pdu_word_if                 word_i,
  pdu_date_if                 date_i,
  output int unsigned         mismatch_cnt_o,
  output int unsigned         pending_o,
  output int unsigned         words_live_o,
  output int unsigned         words_ignored_o,
  output int unsigned         dates_checked_o
);

  typedef struct packed {
    logic [DayBits-1:0]   day;
    logic [MonthBits-1:0] month;
    logic [YearBits-1:0]  year;
    logic                 last_of_run;
  } date_rec_t;

  logic [CountBits-1:0] job_dates;
  logic [CountBits-1:0] job_progress;
  logic [CcBits-1:0]    split_len;
  logic [CarryBits-1:0] split_bits;
  logic                 split_ok;
  date_rec_t            dates_due[$];
  int unsigned          mismatches;
  int unsigned          words_live;
  int unsigned          words_ignored;
  int unsigned          dates_checked;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic restart_job();
    job_progress = '0;
    split_len    = '0;
    split_bits   = '0;
    split_ok     = 1'b1;
  endtask

  function automatic date_rec_t split_fields(input date_t d);
    date_rec_t r;
    r.day         = d[DayBits-1:0];
    r.month       = d[DayBits +: MonthBits];
    r.year        = YearBits'(d[DateBits-1:DayBits+MonthBits]) + YearBase;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic unpack_word(input logic [WordBits-1:0] w, input logic par);
    date_rec_t           found [Slots];
    int unsigned         n;
    int unsigned         pos;
    logic                good;
    logic [WordBits-1:0] mix;
    n    = 0;
    pos  = 0;
    good = ((^w) == par);
    if (job_progress >= job_dates) begin
      words_ignored++;
      return;
    end
    words_live++;
    // The low bits of a date split across the boundary sit below the new word's bits.
    if (split_len != 0) begin
      mix = WordBits'(split_bits) | (w << split_len);
      if (split_ok && good) begin
        found[n] = split_fields(mix[DateBits-1:0]);
        n++;
      end
      job_progress++;
      pos = DateBits - split_len;
    end
    split_len  = '0;
    split_bits = '0;
    split_ok   = 1'b1;
    while (job_progress < job_dates && pos + DateBits <= WordBits) begin
      mix = w >> pos;
      if (good) begin
        found[n] = split_fields(mix[DateBits-1:0]);
        n++;
      end
      job_progress++;
      pos += DateBits;
    end
    // Leftover bits only start a split date when the job still wants more dates.
    if (job_progress < job_dates && pos < WordBits) begin
      split_len  = CcBits'(WordBits - pos);
      split_bits = CarryBits'(w >> pos);
      split_ok   = good;
    end
    if (n > 0) found[n-1].last_of_run = 1'b1;
    for (int k = 0; k < n; k++) dates_due.push_back(found[k]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    date_rec_t want;
    if (!rst_ni) begin
      job_dates = '0;
      restart_job();
      dates_due.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[AddrBits-1:2] == RegIdxDateCount) begin
        job_dates = pwdata[CountBits-1:0];
        restart_job();
      end
      if (date_i.valid && date_i.ready) begin
        dates_checked++;
        if (dates_due.size() == 0) begin
          report_mismatch($sformatf("date %0d arrived with nothing outstanding (%0d/%0d/%0d)",
                                    dates_checked, date_i.day, date_i.month, date_i.year));
        end else begin
          want = dates_due.pop_front();
          if (date_i.day != want.day)
            report_mismatch($sformatf("date %0d day %0d, predicted %0d",
                                      dates_checked, date_i.day, want.day));
          if (date_i.month != want.month)
            report_mismatch($sformatf("date %0d month %0d, predicted %0d",
                                      dates_checked, date_i.month, want.month));
          if (date_i.year != want.year)
            report_mismatch($sformatf("date %0d year %0d, predicted %0d",
                                      dates_checked, date_i.year, want.year));
          if (date_i.last_of_run != want.last_of_run)
            report_mismatch($sformatf("date %0d last_of_run %0b, predicted %0b",
                                      dates_checked, date_i.last_of_run, want.last_of_run));
        end
      end
      if (word_i.valid && word_i.ready) unpack_word(word_i.data_word, word_i.parity_bit);
    end
    mismatch_cnt_o  <= mismatches;
    pending_o       <= dates_due.size();
    words_live_o    <= words_live;
    words_ignored_o <= words_ignored;
    dates_checked_o <= dates_checked;
  end

endmodule

### dv/parity_checked_date_unpacker_tb.sv
// Top of the date unpacker testbench: clock, reset, register writes, word and date traffic.
`timescale 1ns / 100ps

module parity_checked_date_unpacker_tb import pdu_pkg::*;;

  localparam int unsigned RandomWords   = 480;
  localparam int unsigned HoldOffCycles = 200;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned StuckLimit    = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  pdu_word_if word_if ();
  pdu_date_if date_if ();

  int unsigned mismatch_cnt;
  int unsigned dates_pending;
  int unsigned words_live;
  int unsigned words_ignored;
  int unsigned dates_checked;

  bit          steady;
  bit          hold_off_req;
  int unsigned hold_offs;
  int unsigned cfg_writes;
  int unsigned stuck_cycles;

  parity_checked_date_unpacker DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .word_i  (word_if),
    .date_o  (date_if)
  );

  pdu_date_check u_date_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .word_i          (word_if),
    .date_i          (date_if),
    .mismatch_cnt_o  (mismatch_cnt),
    .pending_o       (dates_pending),
    .words_live_o    (words_live),
    .words_ignored_o (words_ignored),
    .dates_checked_o (dates_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic write_date_count(input logic [CountBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegIdxDateCount, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    cfg_writes++;
  endtask

  // spoil flips the parity bit so that the word is flagged as corrupt.
  task automatic offer_word(input logic [WordBits-1:0] w, input logic spoil);
    int unsigned gap;
    word_if.valid      <= 1'b1;
    word_if.data_word  <= w;
    word_if.parity_bit <= (^w) ^ spoil;
    do @(posedge clk_i); while (!word_if.ready);
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      word_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_word(output logic [WordBits-1:0] w, output logic spoil);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w    = $urandom;
    if (pick < 4) w = '0;
    else if (pick < 8) w = '1;
    else if (pick < 12) w = 32'h1 << $urandom_range(0, 31);
    spoil = ($urandom_range(0, 99) < 12);
  endtask

  // A word that yields no date may still be in flight when the last date shows up.
  task automatic finish_phase();
    word_if.valid <= 1'b0;
    do @(posedge clk_i); while (dates_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int unsigned run_len;
    int unsigned stall;
    date_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        date_if.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
        hold_offs++;
      end
      date_if.ready <= 1'b1;
      run_len = $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      stall = steady ? 0 : gap_len();
      if (stall > 0) begin
        date_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((word_if.valid && word_if.ready) || (date_if.valid && date_if.ready) ||
        (psel && penable)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckLimit) begin
      $display("watchdog: no transfer for %0d cycles", stuck_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [WordBits-1:0]  w;
    logic                 spoil;
    logic [CountBits-1:0] job;
    int unsigned          n_words;
    int unsigned          pass_no;
    int unsigned          live_base;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    word_if.valid      <= 1'b0;
    word_if.data_word  <= '0;
    word_if.parity_bit <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the job is empty, so words are consumed without output.
    offer_word(32'h1234_5678, 1'b0);
    offer_word(32'hFFFF_FFFF, 1'b1);
    finish_phase();

    // Two dates in the first word, the third split across the boundary, then the job is over.
    write_date_count(16'd3);
    offer_word(32'h0000_0000, 1'b0);
    offer_word(32'hFFFF_FFFF, 1'b0);
    offer_word(32'hFFFF_FFFF, 1'b0);
    finish_phase();

    // A single date; the tail bits must be dropped.
    write_date_count(16'd1);
    offer_word(32'hF0F0_A5C3, 1'b0);
    offer_word(32'h0F0F_5A3C, 1'b0);
    finish_phase();

    // Longest job: corrupt words alone, around split dates and at field extremes.
    write_date_count(16'hFFFF);
    offer_word(32'hFFFF_FFFF, 1'b1);
    offer_word(32'h0000_0000, 1'b0);
    offer_word(32'hAAAA_AAAA, 1'b0);
    offer_word(32'h5555_5555, 1'b0);
    offer_word(32'h0000_0001, 1'b1);
    offer_word(32'h8000_0000, 1'b0);
    offer_word(32'hDEAD_BEEF, 1'b0);
    offer_word(32'h0123_4567, 1'b1);
    offer_word(32'h89AB_CDEF, 1'b0);
    offer_word(32'hFEDC_BA98, 1'b0);
    offer_word(32'h7654_3210, 1'b0);
    offer_word(32'hC000_0003, 1'b0);
    offer_word(32'h1FFF_0000, 1'b1);
    offer_word(32'h0000_FFFE, 1'b0);
    offer_word(32'h7FFF_7FFF, 1'b0);
    finish_phase();

    live_base = words_live;
    pass_no   = 0;
    while (words_live - live_base < RandomWords) begin
      steady = ($urandom_range(0, 3) == 0);
      if (pass_no == 1) begin
        // The output stalls for a long stretch while words keep coming.
        job          = 16'hFFFF;
        n_words      = 60;
        steady       = 1'b1;
        hold_off_req = 1'b1;
      end else if (pass_no == 3) begin
        job     = '0;
        n_words = 4;
      end else begin
        job = CountBits'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, 120));
        n_words = (job * DateBits + WordBits - 1) / WordBits + $urandom_range(0, 2);
      end
      write_date_count(job);
      repeat (n_words) begin
        random_word(w, spoil);
        offer_word(w, spoil);
      end
      finish_phase();
      pass_no++;
    end
    steady = 1'b0;
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d register writes, %0d words unpacked, %0d words after the job had ended",
             cfg_writes, words_live, words_ignored);
    $display("%0d dates compared, %0d long output stalls", dates_checked, hold_offs);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
